FILE: hdl/bbm_pkg.sv
// Package for the block background masker.
// Holds widths, register codes, payload structs and the controller state type.
// No dependencies; read first by every other file.
package bbm_pkg;

    localparam int MAX_BLOCK_DEF = 8;
    localparam int CH_W          = 8;
    localparam int THR_W         = 10;
    localparam int SIZE_W        = 4;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;
    localparam int DIFF_MAX      = 381;

    localparam int REG_THRESH = 0;
    localparam int REG_SIZE   = 1;

    typedef struct packed {
        logic [CH_W-1:0] pix_c0;
        logic [CH_W-1:0] pix_c1;
        logic [CH_W-1:0] pix_c2;
        logic [CH_W-1:0] bg_c0;
        logic [CH_W-1:0] bg_c1;
        logic [CH_W-1:0] bg_c2;
    } t_pix;

    typedef struct packed {
        logic [CH_W-1:0] out_c0;
        logic [CH_W-1:0] out_c1;
        logic [CH_W-1:0] out_c2;
        logic            block_is_bg;
        logic            last_of_block;
    } t_res;

    typedef enum logic [1:0] {
        ST_FILL,
        ST_JUDGE,
        ST_DRAIN
    } t_state;

endpackage

FILE: hdl/bbm_if.sv
// Stream interfaces for the block background masker: pixel input and result output.
// Depends on bbm_pkg for the payload structs.
interface bbm_pix_if;
    logic         valid;
    logic         ready;
    bbm_pkg::t_pix payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface bbm_res_if;
    logic         valid;
    logic         ready;
    bbm_pkg::t_res payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: hdl/block_background_masker.sv
// Top level of the block background masker: fill controller, block buffer and output stage.
// Depends on bbm_pkg and the stream interfaces in bbm_if.sv.
//
// Usage: pixels of one square block arrive on i_pix, row by row, each with the
// background mean at its position. A transfer is taken when valid and ready are high.
// Each pixel is written to the block buffer (one write port) and its weighted
// difference added to a running sum; a pixel is taken every cycle while filling.
// The cycle after the last pixel the sum is compared with diff_threshold*n*n,
// then the buffer is read back once into the output register on o_res, one entry a
// cycle while the receiver accepts. Filling, judging and draining take turns; the
// first result is loaded by the first read in the drain state, after the judge state.
// Input is held off (ready low) from the last pixel until the final read is issued;
// the next block may then start while the last result still waits in the output register.
// A stalled receiver holds the output register and pauses the buffer reads.
// Reset clears the controller, the sum and the fill count, and sets the registers to
// threshold 0 and block size 8; the buffer itself needs no clearing.
// Configuration is written over the APB port at byte addresses 0 and 4.
module block_background_masker #(
    parameter int MAX_BLOCK = bbm_pkg::MAX_BLOCK_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    bbm_pix_if.sink                     i_pix,
    bbm_res_if.source                   o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bbm_pkg::PADDR_W-1:0] paddr,
    input  logic [bbm_pkg::PDATA_W-1:0] pwdata,
    output logic [bbm_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int DEPTH = MAX_BLOCK * MAX_BLOCK;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int NW    = $clog2(MAX_BLOCK + 1);
    localparam int SW    = $clog2(DEPTH * bbm_pkg::DIFF_MAX + 1);
    localparam int LW    = bbm_pkg::THR_W + CW;
    localparam int CMPW  = (SW > LW) ? SW : LW;
    localparam int CH_W  = bbm_pkg::CH_W;
    localparam int PIX_W = 3 * CH_W;

    logic [bbm_pkg::THR_W-1:0]  r_thr;
    logic [bbm_pkg::SIZE_W-1:0] r_size;

    bbm_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [CW-1:0]   r_rd, n_rd;
    logic [SW-1:0]   r_sum, n_sum;
    logic            r_bg, n_bg;

    logic            r_ov;
    logic            r_obg;
    logic            r_olast;
    logic [PIX_W-1:0] r_rdata;

    logic [PIX_W-1:0] mem [DEPTH];

    logic            cfg_wr;
    logic            in_take;
    logic            wr_en;
    logic            rd_en;
    logic            rd_last;
    logic [NW-1:0]   side;
    logic [CW-1:0]   total;
    logic [LW-1:0]   limit;
    logic [CH_W-1:0] d0, d1, d2;
    logic [SW-1:0]   step_sum;

    function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= '0;
            r_size <= bbm_pkg::SIZE_W'(8);
        end else if (cfg_wr) begin
            if (paddr[2] == 1'(bbm_pkg::REG_SIZE)) begin
                r_size <= pwdata[bbm_pkg::SIZE_W-1:0];
            end else begin
                r_thr <= pwdata[bbm_pkg::THR_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == 1'(bbm_pkg::REG_SIZE)) begin
            prdata = bbm_pkg::PDATA_W'(r_size);
        end else begin
            prdata = bbm_pkg::PDATA_W'(r_thr);
        end
    end

    // Block geometry and limit
    always_comb begin
        if (r_size == '0) begin
            side = NW'(1);
        end else if (r_size > bbm_pkg::SIZE_W'(MAX_BLOCK)) begin
            side = NW'(MAX_BLOCK);
        end else begin
            side = NW'(r_size);
        end
    end

    assign total = CW'(side) * CW'(side);
    assign limit = LW'(r_thr) * LW'(total);

    // Pixel difference
    assign d0 = abs_diff(i_pix.payload.pix_c0, i_pix.payload.bg_c0);
    assign d1 = abs_diff(i_pix.payload.pix_c1, i_pix.payload.bg_c1);
    assign d2 = abs_diff(i_pix.payload.pix_c2, i_pix.payload.bg_c2);
    assign step_sum = r_sum + SW'(d0) + SW'(d1 >> 2) + SW'(d2 >> 2);

    assign in_take = i_pix.valid && i_pix.ready;
    assign rd_last = (r_rd + CW'(1)) == r_cnt;

    // Controller
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_rd        = r_rd;
        n_sum       = r_sum;
        n_bg        = r_bg;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        i_pix.ready = 1'b0;
        unique case (r_state)
            bbm_pkg::ST_FILL: begin
                i_pix.ready = 1'b1;
                if (i_pix.valid) begin
                    wr_en = 1'b1;
                    n_sum = step_sum;
                    n_cnt = r_cnt + CW'(1);
                    if (n_cnt >= total) begin
                        n_state = bbm_pkg::ST_JUDGE;
                    end
                end
            end
            bbm_pkg::ST_JUDGE: begin
                n_bg    = CMPW'(r_sum) <= CMPW'(limit);
                n_sum   = '0;
                n_rd    = '0;
                n_state = bbm_pkg::ST_DRAIN;
            end
            bbm_pkg::ST_DRAIN: begin
                rd_en = !r_ov || o_res.ready;
                if (rd_en) begin
                    n_rd = r_rd + CW'(1);
                    if (rd_last) begin
                        n_cnt   = '0;
                        n_state = bbm_pkg::ST_FILL;
                    end
                end
            end
            default: begin
                n_state = bbm_pkg::ST_FILL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bbm_pkg::ST_FILL;
            r_cnt   <= '0;
            r_rd    <= '0;
            r_sum   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_rd    <= n_rd;
            r_sum   <= n_sum;
            if (rd_en) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bg <= n_bg;
        if (rd_en) begin
            r_obg   <= r_bg;
            r_olast <= rd_last;
        end
    end

    // Block buffer
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_cnt[AW-1:0]] <= {i_pix.payload.pix_c2, i_pix.payload.pix_c1,
                                   i_pix.payload.pix_c0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= mem[r_rd[AW-1:0]];
        end
    end

    // Output stage
    assign o_res.valid = r_ov;
    always_comb begin
        o_res.payload.out_c0        = r_obg ? '0 : r_rdata[CH_W-1:0];
        o_res.payload.out_c1        = r_obg ? '0 : r_rdata[2*CH_W-1:CH_W];
        o_res.payload.out_c2        = r_obg ? '0 : r_rdata[3*CH_W-1:2*CH_W];
        o_res.payload.block_is_bg   = r_obg;
        o_res.payload.last_of_block = r_olast;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("fill count beyond buffer depth");

    a_end_judge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && ((r_cnt + CW'(1)) >= total)) |=> (r_state == bbm_pkg::ST_JUDGE))
        else $error("block end not followed by judgement");

    a_no_wr_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bbm_pkg::ST_DRAIN) |-> (!wr_en && !i_pix.ready))
        else $error("buffer written while draining");

    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> (r_rd < r_cnt))
        else $error("read beyond stored pixels");

    a_drain_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_en && rd_last) |=> (r_ov && r_olast && (r_state == bbm_pkg::ST_FILL)))
        else $error("final read did not mark last result");

endmodule
